FILE: rtl/core/shamh_pkg.sv
// Shared types and constants of the SHA-256 message hasher.
// Depends on nothing; all modules of the block use it.
`default_nettype none

package shamh_pkg;

   // Eight 32-bit words, entry 0 is H0 (or working variable a).
   typedef logic [7:0][31:0] word8_type;

   // Control from the sequencer to the compression datapath.
   typedef struct packed {
      logic       init;       // copy the hash words into the working variables
      logic       shift_in;   // shift a buffered message word into the schedule
      logic       round;      // run one compression round
      logic [5:0] round_idx;  // round number for the constant lookup
   } cmp_ctrl_type;

   // Initial hash value, H7 in the top slot down to H0 in the bottom slot.
   localparam word8_type HASH_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   // Round constants.
   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

`default_nettype wire

FILE: rtl/core/shamh_if.sv
// Valid/ready channel interfaces for message words and digest words.
// Depends on nothing; used by the top level of the hasher.
`default_nettype none

// Message word channel.
interface shamh_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [5:0]  valid_bits;
   logic        final_word;

   modport source (output valid, output data_word, output valid_bits,
                   output final_word, input ready);
   modport sink (input valid, input data_word, input valid_bits,
                 input final_word, output ready);
endinterface

// Digest word channel.
interface shamh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        digest_last;

   modport source (output valid, output digest_word, output digest_last, input ready);
   modport sink (input valid, input digest_word, input digest_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sha256_message_hasher.sv
// SHA-256 message hasher.
//
// The message arrives on req_ch as big-endian 32-bit words, one item per
// word; the item with final_word set carries 0 to 32 valid leading bits in
// valid_bits (values above 32 count as 32; valid_bits is ignored on other
// words). Words are written into a 16-entry block buffer memory. When it
// fills, the block is read back into the schedule window and compressed at
// one round per cycle by the single round unit, then added into the hash
// words; no message word is taken meanwhile. The final word starts the
// padding sequencer, which writes one word per cycle, pausing while a filled
// block is compressed, and may run one or two compressions; the eight digest
// words then leave on rsp_ch, H0 first, digest_last on H7, and the hash words
// return to the initial value for the next message.
// The digest sits in its own output register, so the next message is taken
// while the receiver stalls; a second digest waits until the first is gone.
// Reset is synchronous and leaves the block idle with an empty buffer, zero
// length and the initial hash value; no clearing pass is needed.
// Depends on shamh_pkg, shamh_if and shamh_compress.
`default_nettype none

module sha256_message_hasher (
   input  wire logic  clock,
   input  wire logic  reset,
   shamh_req_if.sink  req_ch,
   shamh_rsp_if.source rsp_ch
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PAD    = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_ROUND  = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   localparam logic [2:0] PH_DATA  = 3'd0;
   localparam logic [2:0] PH_MARK  = 3'd1;
   localparam logic [2:0] PH_ZERO  = 3'd2;
   localparam logic [2:0] PH_LENHI = 3'd3;
   localparam logic [2:0] PH_LENLO = 3'd4;
   localparam logic [2:0] PH_DONE  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  eff_phase;
   logic [3:0]  fill_ff, fill_in;
   logic [63:0] msg_bits_ff, msg_bits_in;
   logic [63:0] total_ff, total_in;
   logic [31:0] pad_word_ff, pad_word_in;
   logic        full_ff, full_in;
   logic        pad_active_ff, pad_active_in;
   logic [4:0]  ld_cnt_ff, ld_cnt_in;
   logic        rd_valid_ff, rd_valid_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [3:0]  out_cnt_ff, out_cnt_in;
   shamh_pkg::word8_type hash_ff, hash_in;
   shamh_pkg::word8_type dig_ff, dig_in;
   shamh_pkg::word8_type vars;
   shamh_pkg::cmp_ctrl_type ctrl;

   logic        req_fire, rsp_fire;
   logic [5:0]  nbits;
   logic [31:0] data_mask, padded;
   logic        wr_en;
   logic [3:0]  wr_addr;
   logic [31:0] wr_data;
   logic [31:0] buf_mem [16];
   logic [31:0] rd_data_ff;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign req_fire           = req_ch.valid & req_ch.ready;
   assign rsp_ch.valid       = (out_cnt_ff != 4'd0);
   assign rsp_ch.digest_word = dig_ff[0];
   assign rsp_ch.digest_last = (out_cnt_ff == 4'd1);
   assign rsp_fire           = rsp_ch.valid & rsp_ch.ready;

   // Final word: clamp the bit count, clear invalid bits, append the 1 bit.
   always_comb begin
      nbits     = (req_ch.valid_bits > 6'd32) ? 6'd32 : req_ch.valid_bits;
      data_mask = ~(32'hffffffff >> nbits[4:0]);
      padded    = nbits[5] ? req_ch.data_word
                           : ((req_ch.data_word & data_mask) | (32'h80000000 >> nbits[4:0]));
   end

   // Zero fill ends when two slots remain for the length.
   assign eff_phase = ((phase_ff == PH_ZERO) && (fill_ff == 4'd14)) ? PH_LENHI : phase_ff;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      fill_in       = fill_ff;
      msg_bits_in   = msg_bits_ff;
      total_in      = total_ff;
      pad_word_in   = pad_word_ff;
      full_in       = full_ff;
      pad_active_in = pad_active_ff;
      ld_cnt_in     = ld_cnt_ff;
      rd_valid_in   = 1'b0;
      rnd_in        = rnd_ff;
      hash_in       = hash_ff;
      dig_in        = dig_ff;
      out_cnt_in    = out_cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_ff;
      wr_data       = req_ch.data_word;
      ctrl          = '0;
      ctrl.round_idx = rnd_ff;

      // Digest words leave one per handshake.
      if (rsp_fire) begin
         dig_in     = {32'd0, dig_ff[7:1]};
         out_cnt_in = out_cnt_ff - 4'd1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.final_word) begin
                  total_in      = msg_bits_ff + {58'd0, nbits};
                  pad_word_in   = padded;
                  full_in       = nbits[5];
                  phase_in      = PH_DATA;
                  pad_active_in = 1'b1;
                  state_in      = S_PAD;
               end else begin
                  wr_en       = 1'b1;
                  fill_in     = fill_ff + 4'd1;
                  msg_bits_in = msg_bits_ff + 64'd32;
                  if (fill_ff == 4'd15) begin
                     state_in = S_LOAD;
                  end
               end
            end
         end
         S_PAD: begin
            wr_en   = 1'b1;
            fill_in = fill_ff + 4'd1;
            case (eff_phase)
               PH_DATA: begin
                  wr_data  = pad_word_ff;
                  phase_in = full_ff ? PH_MARK : PH_ZERO;
               end
               PH_MARK: begin
                  wr_data  = 32'h80000000;
                  phase_in = PH_ZERO;
               end
               PH_LENHI: begin
                  wr_data  = total_ff[63:32];
                  phase_in = PH_LENLO;
               end
               PH_LENLO: begin
                  wr_data  = total_ff[31:0];
                  phase_in = PH_DONE;
               end
               default: begin
                  wr_data  = 32'd0;
                  phase_in = PH_ZERO;
               end
            endcase
            if (fill_ff == 4'd15) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            ctrl.init     = (ld_cnt_ff == 5'd0);
            ctrl.shift_in = rd_valid_ff;
            rd_valid_in   = ~ld_cnt_ff[4];
            if (ld_cnt_ff[4]) begin
               ld_cnt_in = 5'd0;
               rnd_in    = 6'd0;
               state_in  = S_ROUND;
            end else begin
               ld_cnt_in = ld_cnt_ff + 5'd1;
            end
         end
         S_ROUND: begin
            ctrl.round = 1'b1;
            rnd_in     = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + vars[i];
            end
            if (!pad_active_ff) begin
               state_in = S_IDLE;
            end else if (phase_ff == PH_DONE) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_PAD;
            end
         end
         S_FINISH: begin
            // Wait for the previous digest to drain, then hand this one over.
            if (out_cnt_ff == 4'd0) begin
               dig_in        = hash_ff;
               out_cnt_in    = 4'd8;
               hash_in       = shamh_pkg::HASH_IV;
               msg_bits_in   = 64'd0;
               pad_active_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Block buffer memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= buf_mem[ld_cnt_ff[3:0]];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_DATA;
         fill_ff       <= 4'd0;
         msg_bits_ff   <= 64'd0;
         pad_active_ff <= 1'b0;
         ld_cnt_ff     <= 5'd0;
         rd_valid_ff   <= 1'b0;
         rnd_ff        <= 6'd0;
         out_cnt_ff    <= 4'd0;
         hash_ff       <= shamh_pkg::HASH_IV;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         fill_ff       <= fill_in;
         msg_bits_ff   <= msg_bits_in;
         pad_active_ff <= pad_active_in;
         ld_cnt_ff     <= ld_cnt_in;
         rd_valid_ff   <= rd_valid_in;
         rnd_ff        <= rnd_in;
         out_cnt_ff    <= out_cnt_in;
         hash_ff       <= hash_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      total_ff    <= total_in;
      pad_word_ff <= pad_word_in;
      full_ff     <= full_in;
      dig_ff      <= dig_in;
   end

   shamh_compress u_compress (
      .clock     (clock),
      .ctrl      (ctrl),
      .load_word (rd_data_ff),
      .hash_in   (hash_ff),
      .vars_out  (vars)
   );

   // The round loop only ends after the last round.
   a_round_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && state_in != S_ROUND) |-> rnd_ff == 6'd63)
      else $error("round loop left early");

   // The low length word always closes a block.
   a_len_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAD && eff_phase == PH_LENLO) |-> fill_ff == 4'd15)
      else $error("length word not in the last buffer slot");

   // A new digest never overwrites one still being sent.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && state_in == S_IDLE) |-> out_cnt_ff == 4'd0)
      else $error("digest overwritten");

   // After the marked last word the output is empty in the next cycle.
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.digest_last) |=> out_cnt_ff == 4'd0)
      else $error("digest count wrong after last word");

   // Message words are only taken with no padding in flight.
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !pad_active_ff)
      else $error("item accepted during padding");

endmodule

`default_nettype wire

FILE: rtl/core/shamh_compress.sv
// Compression datapath: 16-word schedule window, working variables a..h
// and the round function. Depends on shamh_pkg.
`default_nettype none

module shamh_compress (
   input  wire logic                   clock,
   input  wire shamh_pkg::cmp_ctrl_type ctrl,
   input  wire logic [31:0]            load_word,
   input  wire shamh_pkg::word8_type   hash_in,
   output shamh_pkg::word8_type        vars_out
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {x, x} >> n;
      return dbl[31:0];
   endfunction

   logic [31:0]          w_ff [16];
   shamh_pkg::word8_type v_ff;
   shamh_pkg::word8_type v_in;
   logic [31:0]          sched_new;
   logic [31:0]          sig0, sig1, big0, big1, ch, maj, t1, t2;

   // Message schedule: the next word from the sliding window.
   always_comb begin
      sig0      = rotr(w_ff[1], 5'd7) ^ rotr(w_ff[1], 5'd18) ^ (w_ff[1] >> 3);
      sig1      = rotr(w_ff[14], 5'd17) ^ rotr(w_ff[14], 5'd19) ^ (w_ff[14] >> 10);
      sched_new = w_ff[0] + sig0 + w_ff[9] + sig1;
   end

   // One round; entry 0 is a and entry 7 is h.
   always_comb begin
      big1 = rotr(v_ff[4], 5'd6) ^ rotr(v_ff[4], 5'd11) ^ rotr(v_ff[4], 5'd25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + shamh_pkg::ROUND_K[ctrl.round_idx] + w_ff[0];
      big0 = rotr(v_ff[0], 5'd2) ^ rotr(v_ff[0], 5'd13) ^ rotr(v_ff[0], 5'd22);
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;
      v_in = {v_ff[6], v_ff[5], v_ff[4], v_ff[3] + t1,
              v_ff[2], v_ff[1], v_ff[0], t1 + t2};
   end

   // Window shifts on a load from the buffer and on every round.
   always_ff @(posedge clock) begin
      if (ctrl.shift_in || ctrl.round) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= ctrl.round ? sched_new : load_word;
      end
      if (ctrl.init) begin
         v_ff <= hash_in;
      end else if (ctrl.round) begin
         v_ff <= v_in;
      end
   end

   assign vars_out = v_ff;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the SHA-256 message hasher: streams messages in,
// predicts every digest word, and checks the words that come back in order.
// Depends on the RTL interfaces shamh_req_if and shamh_rsp_if and the top level.

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 200;

   // One message word as it travels on the request channel.
   typedef struct packed {
      bit [31:0] data_word;
      bit [5:0]  valid_bits;
      bit        final_word;
   } message_word_type;

   // One digest word as it should appear on the response channel.
   typedef struct {
      bit [31:0] digest_word;
      bit        digest_last;
   } digest_entry_type;

   localparam bit [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam bit [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   shamh_req_if req_bus ();
   shamh_rsp_if rsp_bus ();

   sha256_message_hasher u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Stimulus and expectation stores.
   message_word_type pending_words[$];
   digest_entry_type digest_expected[$];

   // Predicted hashing state.
   bit [31:0] chain_hash [8];
   bit [31:0] block_words [16];
   bit [3:0]  block_fill;
   bit [63:0] message_length;

   int total_items;
   int words_accepted;
   int messages_hashed;
   int over_range_finals;
   int digests_checked;
   int failures;
   int cycle_count;
   int send_gap;
   int stall_gap;
   int hold_left;
   bit hold_done;

   function automatic bit [31:0] rotr(input bit [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64 rounds over the buffered block and fold them into the chain.
   task automatic compress_block();
      bit [31:0] sched [64];
      bit [31:0] a, b, c, d, e, f, g, h;
      bit [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) sched[i] = block_words[i];
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
      e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + SHA_K[i] + sched[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
      chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
   endtask

   task automatic absorb_word(input bit [31:0] w);
      block_words[block_fill] = w;
      block_fill = block_fill + 4'd1;
      if (block_fill == 4'd0) compress_block();
   endtask

   // Advance the predicted state by one message word; a final word pads the
   // message and queues the eight digest words it produces.
   task automatic predict_digest(input message_word_type item);
      int               nbits;
      bit [63:0]        total_bits;
      bit [31:0]        keep;
      digest_entry_type entry;
      if (!item.final_word) begin
         absorb_word(item.data_word);
         message_length += 64'd32;
      end else begin
         nbits = (item.valid_bits > 6'd32) ? 32 : int'(item.valid_bits);
         total_bits = message_length + 64'(nbits);
         if (nbits == 32) begin
            absorb_word(item.data_word);
            absorb_word(32'h8000_0000);
         end else begin
            keep = (nbits == 0) ? 32'h0 : (32'hffff_ffff << (32 - nbits));
            absorb_word((item.data_word & keep) | (32'h8000_0000 >> nbits));
         end
         while (block_fill != 4'd14) absorb_word(32'h0);
         absorb_word(total_bits[63:32]);
         absorb_word(total_bits[31:0]);
         for (int i = 0; i < 8; i++) begin
            entry.digest_word = chain_hash[i];
            entry.digest_last = (i == 7);
            digest_expected.insert(digest_expected.size(), entry);
         end
         chain_hash = SHA_IV;
         message_length = 64'd0;
         block_fill = 4'd0;
      end
   endtask

   task automatic add_word(input bit [31:0] data, input bit [5:0] nbits, input bit fin);
      message_word_type entry;
      entry.data_word  = data;
      entry.valid_bits = nbits;
      entry.final_word = fin;
      pending_words.insert(pending_words.size(), entry);
   endtask

   // Clock.
   initial begin
      forever #10 clock = ~clock;
   end

   // Reset and known levels on every input from time zero.
   initial begin
      req_bus.valid = 1'b0;
      req_bus.data_word = 32'h0;
      req_bus.valid_bits = 6'h0;
      req_bus.final_word = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Build the message stream: directed corner cases first, then random messages.
   initial begin : stimulus_build
      int n_body;
      int pick;
      bit [5:0] last_bits;
      // Empty message; the data bits must all be masked off.
      add_word(32'hffff_ffff, 6'd0, 1'b1);
      // The classic three-byte message.
      add_word(32'h6162_6300, 6'd24, 1'b1);
      // Fully valid final word, so the padding bit opens the next word.
      add_word(32'h0000_0000, 6'd32, 1'b1);
      // Bit counts above 32 on the final word saturate.
      add_word(32'hffff_ffff, 6'd63, 1'b1);
      add_word(32'h8000_0001, 6'd33, 1'b1);
      // A single valid bit with all low bits set to be cleared.
      add_word(32'hffff_ffff, 6'd1, 1'b1);
      // A short non-final word still counts all 32 bits.
      add_word(32'hffff_ffff, 6'd0, 1'b0);
      add_word(32'h0000_0000, 6'd31, 1'b1);
      // Thirteen body words and a full final word: padding spills into a second block.
      for (int i = 0; i < 13; i++)
         add_word(i[0] ? 32'hffff_ffff : 32'h0000_0000, i[0] ? 6'd63 : 6'd0, 1'b0);
      add_word(32'hdead_beef, 6'd32, 1'b1);

      // Random messages, mostly short, some spanning blocks, some ending near a
      // block boundary.
      while (pending_words.size() < 430) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) n_body = $urandom_range(0, 15);
         else if (pick <= 7) n_body = $urandom_range(16, 40);
         else n_body = 16 * $urandom_range(0, 1) + $urandom_range(13, 15);
         for (int i = 0; i < n_body; i++) add_word($urandom, 6'($urandom_range(0, 63)), 1'b0);
         if ($urandom_range(0, 3) == 0) last_bits = 6'($urandom_range(33, 63));
         else last_bits = 6'($urandom_range(0, 32));
         add_word($urandom, last_bits, 1'b1);
      end
      total_items = pending_words.size();
   end

   // Request driver: predicts on every accepted item and presents the next one,
   // with random bursts of idle cycles outside the calm stretches.
   always @(posedge clock) begin : message_driver
      message_word_type item;
      bit calm;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data_word <= 32'h0;
         req_bus.valid_bits <= 6'h0;
         req_bus.final_word <= 1'b0;
         send_gap = 0;
         chain_hash = SHA_IV;
         block_fill = 4'd0;
         message_length = 64'd0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            item = '{req_bus.data_word, req_bus.valid_bits, req_bus.final_word};
            predict_digest(item);
            if (item.final_word) begin
               messages_hashed++;
               if (item.valid_bits > 6'd32) over_range_finals++;
            end
            words_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            calm = (words_accepted * 100 >= total_items * 85) || ((words_accepted / 40) % 4 == 3);
            if (send_gap != 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 5);
               req_bus.valid <= 1'b0;
            end else begin
               item = pending_words.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.data_word <= item.data_word;
               req_bus.valid_bits <= item.valid_bits;
               req_bus.final_word <= item.final_word;
            end
         end
      end
   end

   // One long receiver hold-off, so that a digest backs up and the input stalls.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && words_accepted >= 120) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Digest monitor: checks each accepted item against the oldest expectation
   // and drives ready with random stall bursts.
   always @(posedge clock) begin : digest_monitor
      digest_entry_type wanted;
      bit calm;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (digest_expected.size() == 0) begin
               $error("unexpected digest item: digest_word %h digest_last %b",
                      rsp_bus.digest_word, rsp_bus.digest_last);
               failures++;
            end else begin
               wanted = digest_expected.pop_front();
               if (rsp_bus.digest_word !== wanted.digest_word) begin
                  $error("digest_word mismatch: expected %h, actual %h",
                         wanted.digest_word, rsp_bus.digest_word);
                  failures++;
               end
               if (rsp_bus.digest_last !== wanted.digest_last) begin
                  $error("digest_last mismatch: expected %b, actual %b",
                         wanted.digest_last, rsp_bus.digest_last);
                  failures++;
               end
               digests_checked++;
            end
         end
         calm = (words_accepted * 100 >= total_items * 85) || ((cycle_count / 300) % 4 == 3);
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_gap != 0) begin
            stall_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_gap = $urandom_range(0, 5);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("run did not finish within %0d cycles", CYCLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // End of run: all words taken, all digests seen, then a short drain.
   initial begin : run_control
      @(negedge reset);
      while (!(total_items > 0 && words_accepted == total_items && digest_expected.size() == 0))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Hashed %0d messages from %0d words, %0d of them with an over-range bit count.",
               messages_hashed, words_accepted, over_range_finals);
      $display("Checked %0d digest words, including one long receiver hold-off.",
               digests_checked);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
